FILE: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, types and helper functions for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    // Number formats.
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STAGES   = 16;

    // Shift that brings a product (2*QUAT_FRAC_BITS fraction bits) to Q30.
    localparam int Q30_SHIFT = 30 - 2 * QUAT_FRAC_BITS;

    // Field widths.
    localparam int QW     = 16;  // quaternion component
    localparam int PW     = 2 * QW;  // product
    localparam int SUMW   = PW + 1;  // sum of two products
    localparam int OPW    = 36;  // Q30 arctangent operand
    localparam int SW     = 32;  // arcsine argument in Q30
    localparam int RW     = 62;  // square root radicand and remainder
    localparam int RTW    = 31;  // square root result
    localparam int CW     = 38;  // CORDIC vector component
    localparam int ZW     = 36;  // CORDIC angle accumulator, Q32
    localparam int LANES  = 3;   // roll, pitch, yaw
    localparam int ISQ_STAGES = 31;  // one result bit per stage

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    // Angle constants in Q32.
    localparam logic signed [ZW-1:0] PI_Q32      = 36'sh3_243F_6A89;
    localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sh1_921F_B544;
    localparam longint unsigned QUARTER_PI_Q32 = 64'hC90F_DAA2;

    localparam logic signed [OPW-1:0] ONE_Q30 = 36'sd1 <<< 30;
    localparam logic signed [SW-1:0]  ONE_S   = 32'sd1 <<< 30;
    localparam logic signed [SUMW-1:0] SP_LIM = 33'sd1 <<< (2 * QUAT_FRAC_BITS - 1);
    localparam logic [RW-1:0] ONE_Q60 = 62'd1 << 60;

    // Operands carried alongside the square root.
    typedef struct packed {
        logic signed [OPW-1:0] sr;
        logic signed [OPW-1:0] cr;
        logic signed [OPW-1:0] sy;
        logic signed [OPW-1:0] cy;
        logic signed [SW-1:0]  s;
        logic                  clamped;
    } side_t;

    // One CORDIC input vector.
    typedef struct packed {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } vec_t;

    // Restoring division, used only while building the arctangent table.
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q32, rounded, from a Q62 Taylor series.
    function automatic longint unsigned atan_q32(int i);
        longint unsigned acc;
        longint unsigned term;
        acc = '0;
        if (i == 0) begin
            return QUARTER_PI_Q32;
        end
        if (i > 62) begin
            return '0;
        end
        for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
            term = udiv(64'd1 << (62 - (2 * k + 1) * i), longint'(2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return (acc + (64'd1 << 29)) >> 30;
    endfunction

    // Clamp a Q32 angle to +-lim and round half up to ANGLE_FRAC_BITS.
    function automatic logic signed [ZW-1:0] angle_round(logic signed [ZW-1:0] z,
                                                         logic signed [ZW-1:0] lim);
        logic signed [ZW-1:0] zc;
        zc = z;
        if (z > lim) begin
            zc = lim;
        end
        if (z < -lim) begin
            zc = -lim;
        end
        return (zc + (36'sd1 <<< (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
    endfunction

endpackage

FILE: rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Z-Y-X Euler angles (roll, pitch, yaw) from a Q1.14 quaternion, pipelined.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  s_       | in        | s_valid, s_ready, s_qw, s_qx, s_qy, s_qz
//  m_       | out       | m_valid, m_ready, m_roll, m_pitch, m_yaw, m_pitch_clamped
//
// One quaternion enters per cycle unless the result channel stalls. Data runs
// through the front, the bit-per-stage square root, CORDIC and output register.
// Reset clears every valid bit; payload registers are not reset.
// Each stage loads when it is empty or its successor loads, so bubbles fill
// in under a stall and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [qte_pkg::QW-1:0]         s_qw,
    input  logic signed [qte_pkg::QW-1:0]         s_qx,
    input  logic signed [qte_pkg::QW-1:0]         s_qy,
    input  logic signed [qte_pkg::QW-1:0]         s_qz,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [qte_pkg::ROLL_W-1:0]     m_roll,
    output logic signed [qte_pkg::PITCH_W-1:0]    m_pitch,
    output logic signed [qte_pkg::YAW_W-1:0]      m_yaw,
    output logic                                  m_pitch_clamped
);

    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;

    logic                   fr_valid, fr_ready;
    qte_pkg::side_t         fr_side;
    logic [qte_pkg::RW-1:0] fr_rad;

    logic                    sq_valid, sq_ready;
    qte_pkg::side_t          sq_side;
    logic [qte_pkg::RTW-1:0] sq_root;

    qte_pkg::vec_t [qte_pkg::LANES-1:0] cd_vec;
    logic                               cd_valid, cd_ready, cd_clamped;
    logic signed [ZW-1:0]               cd_z [qte_pkg::LANES];
    logic [qte_pkg::LANES-1:0]          cd_zero;

    logic signed [ZW-1:0] roll_q, pitch_q, yaw_q;

    logic                                 m_valid_reg;
    logic signed [qte_pkg::ROLL_W-1:0]    roll_reg;
    logic signed [qte_pkg::PITCH_W-1:0]   pitch_reg;
    logic signed [qte_pkg::YAW_W-1:0]     yaw_reg;
    logic                                 clamped_reg;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .qw        (s_qw),
        .qx        (s_qx),
        .qy        (s_qy),
        .qz        (s_qz),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_side  (fr_side),
        .out_rad   (fr_rad)
    );

    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_side   (fr_side),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // CORDIC operand vectors: roll, pitch (sine over cosine), yaw.
    assign cd_vec[qte_pkg::LANE_ROLL].y  = CW'(sq_side.sr);
    assign cd_vec[qte_pkg::LANE_ROLL].x  = CW'(sq_side.cr);
    assign cd_vec[qte_pkg::LANE_PITCH].y = CW'(sq_side.s);
    assign cd_vec[qte_pkg::LANE_PITCH].x = CW'({1'b0, sq_root});
    assign cd_vec[qte_pkg::LANE_YAW].y   = CW'(sq_side.sy);
    assign cd_vec[qte_pkg::LANE_YAW].x   = CW'(sq_side.cy);

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sq_valid),
        .in_ready    (sq_ready),
        .in_vec      (cd_vec),
        .in_clamped  (sq_side.clamped),
        .out_valid   (cd_valid),
        .out_ready   (cd_ready),
        .out_z       (cd_z),
        .out_zero    (cd_zero),
        .out_clamped (cd_clamped)
    );

    // Range clamp and rounding; a zero vector gives a zero angle.
    assign roll_q  = qte_pkg::angle_round(cd_zero[qte_pkg::LANE_ROLL] ? '0 :
                         cd_z[qte_pkg::LANE_ROLL], qte_pkg::PI_Q32);
    assign pitch_q = qte_pkg::angle_round(cd_zero[qte_pkg::LANE_PITCH] ? '0 :
                         cd_z[qte_pkg::LANE_PITCH], qte_pkg::HALF_PI_Q32);
    assign yaw_q   = qte_pkg::angle_round(cd_zero[qte_pkg::LANE_YAW] ? '0 :
                         cd_z[qte_pkg::LANE_YAW], qte_pkg::PI_Q32);

    // Output register stage.
    assign cd_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cd_ready) begin
            m_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cd_ready) begin
            roll_reg    <= roll_q[qte_pkg::ROLL_W-1:0];
            pitch_reg   <= pitch_q[qte_pkg::PITCH_W-1:0];
            yaw_reg     <= yaw_q[qte_pkg::YAW_W-1:0];
            clamped_reg <= cd_clamped;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_roll          = roll_reg;
    assign m_pitch         = pitch_reg;
    assign m_yaw           = yaw_reg;
    assign m_pitch_clamped = clamped_reg;

endmodule

FILE: rtl/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Three pipeline stages: component products, Q30 operands with the arcsine
// clamp, and the square root radicand 1 - s*s.
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [qte_pkg::QW-1:0]   qw,
    input  logic signed [qte_pkg::QW-1:0]   qx,
    input  logic signed [qte_pkg::QW-1:0]   qy,
    input  logic signed [qte_pkg::QW-1:0]   qz,
    output logic                            out_valid,
    input  logic                            out_ready,
    output qte_pkg::side_t                  out_side,
    output logic [qte_pkg::RW-1:0]          out_rad
);

    localparam int N = 3;
    localparam int PW = qte_pkg::PW;
    localparam int SUMW = qte_pkg::SUMW;
    localparam int OPW = qte_pkg::OPW;
    localparam int SW = qte_pkg::SW;
    localparam int SHL = qte_pkg::Q30_SHIFT + 1;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   load;

    // Stage 0 products.
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PW-1:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;

    // Stage 1 and 2 payload.
    qte_pkg::side_t        side1_reg;
    qte_pkg::side_t        side2_reg;
    logic [qte_pkg::RW-1:0] rad_reg;

    logic signed [SUMW-1:0] sum_r, sum_cr, sum_y, sum_cy, diff_p;
    logic signed [2*SW-1:0] s_sq;

    // Stall chain: a stage loads when it is empty or its successor loads.
    assign load[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_load
        assign load[g] = !vld_reg[g] || load[g+1];
    end
    assign in_ready = load[0];
    assign vld_next = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (load[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Products of the components.
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            p_wx_reg <= qw * qx;
            p_yz_reg <= qy * qz;
            p_xx_reg <= qx * qx;
            p_yy_reg <= qy * qy;
            p_wz_reg <= qw * qz;
            p_xy_reg <= qx * qy;
            p_zz_reg <= qz * qz;
            p_wy_reg <= qw * qy;
            p_zx_reg <= qz * qx;
        end
    end

    // Sums for the three angles.
    assign sum_r  = SUMW'(p_wx_reg) + SUMW'(p_yz_reg);
    assign sum_cr = SUMW'(p_xx_reg) + SUMW'(p_yy_reg);
    assign sum_y  = SUMW'(p_wz_reg) + SUMW'(p_xy_reg);
    assign sum_cy = SUMW'(p_yy_reg) + SUMW'(p_zz_reg);
    assign diff_p = SUMW'(p_wy_reg) - SUMW'(p_zx_reg);

    // Operands in Q30; the arcsine argument saturates at unit magnitude.
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            side1_reg.sr <= OPW'(sum_r) <<< SHL;
            side1_reg.cr <= qte_pkg::ONE_Q30 - (OPW'(sum_cr) <<< SHL);
            side1_reg.sy <= OPW'(sum_y) <<< SHL;
            side1_reg.cy <= qte_pkg::ONE_Q30 - (OPW'(sum_cy) <<< SHL);
            if (diff_p > qte_pkg::SP_LIM) begin
                side1_reg.s       <= qte_pkg::ONE_S;
                side1_reg.clamped <= 1'b1;
            end else if (diff_p < -qte_pkg::SP_LIM) begin
                side1_reg.s       <= -qte_pkg::ONE_S;
                side1_reg.clamped <= 1'b1;
            end else begin
                side1_reg.s       <= SW'(diff_p) <<< SHL;
                side1_reg.clamped <= 1'b0;
            end
        end
    end

    // Radicand for the cosine of pitch.
    assign s_sq = side1_reg.s * side1_reg.s;

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            side2_reg <= side1_reg;
            rad_reg   <= qte_pkg::ONE_Q60 - qte_pkg::RW'(s_sq);
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side2_reg;
    assign out_rad   = rad_reg;

endmodule

FILE: rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per stage, carrying the
// other angle operands alongside.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  qte_pkg::side_t            in_side,
    input  logic [qte_pkg::RW-1:0]    in_rad,
    output logic                      out_valid,
    input  logic                      out_ready,
    output qte_pkg::side_t            out_side,
    output logic [qte_pkg::RTW-1:0]   out_root
);

    localparam int N  = qte_pkg::ISQ_STAGES;
    localparam int RW = qte_pkg::RW;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   load;

    logic [RW-1:0]  rem_reg  [N];
    logic [RW-1:0]  root_reg [N];
    qte_pkg::side_t side_reg [N];

    // Stall chain.
    assign load[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_load
        assign load[g] = !vld_reg[g] || load[g+1];
    end
    assign in_ready = load[0];
    assign vld_next = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (load[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // One trial subtraction per stage, highest bit pair first.
    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - g));
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  root_in;
        logic [RW-1:0]  trial;
        qte_pkg::side_t side_in;

        if (g == 0) begin : g_first
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign trial = root_in + BIT;

        always_ff @(posedge aclk) begin
            if (load[g]) begin
                side_reg[g] <= side_in;
                if (rem_in >= trial) begin
                    rem_reg[g]  <= rem_in - trial;
                    root_reg[g] <= (root_in >> 1) + BIT;
                end else begin
                    rem_reg[g]  <= rem_in;
                    root_reg[g] <= root_in >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_root  = root_reg[N-1][qte_pkg::RTW-1:0];

endmodule

FILE: rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC for three lanes in lockstep: a quadrant stage followed by
// one micro-rotation stage per iteration, giving atan2(y, x) in Q32.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  qte_pkg::vec_t [qte_pkg::LANES-1:0]        in_vec,
    input  logic                                      in_clamped,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [qte_pkg::ZW-1:0]             out_z [qte_pkg::LANES],
    output logic [qte_pkg::LANES-1:0]                 out_zero,
    output logic                                      out_clamped
);

    localparam int N  = STAGES + 1;
    localparam int L  = qte_pkg::LANES;
    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   load;

    logic signed [CW-1:0] x_reg    [N][L];
    logic signed [CW-1:0] y_reg    [N][L];
    logic signed [ZW-1:0] z_reg    [N][L];
    logic [L-1:0]         zero_reg [N];
    logic                 clamp_reg [N];

    // Stall chain.
    assign load[N] = out_ready;
    for (genvar g = 0; g < N; g++) begin : g_load
        assign load[g] = !vld_reg[g] || load[g+1];
    end
    assign in_ready = load[0];
    assign vld_next = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (load[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Flag carried through all stages.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (load[k]) begin
                clamp_reg[k] <= (k == 0) ? in_clamped : clamp_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Quadrant stage: vectors in the left half plane are turned by pi.
    for (genvar l = 0; l < L; l++) begin : g_pre
        always_ff @(posedge aclk) begin
            if (load[0]) begin
                zero_reg[0][l] <= (in_vec[l].x == '0) && (in_vec[l].y == '0);
                if (in_vec[l].x < 0) begin
                    x_reg[0][l] <= -in_vec[l].x;
                    y_reg[0][l] <= -in_vec[l].y;
                    z_reg[0][l] <= (in_vec[l].y < 0) ? -qte_pkg::PI_Q32 : qte_pkg::PI_Q32;
                end else begin
                    x_reg[0][l] <= in_vec[l].x;
                    y_reg[0][l] <= in_vec[l].y;
                    z_reg[0][l] <= '0;
                end
            end
        end
    end

    // Micro-rotation stages; the rotation direction follows the sign of y.
    for (genvar g = 1; g < N; g++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'(qte_pkg::atan_q32(g - 1));
        for (genvar l = 0; l < L; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (load[g]) begin
                    zero_reg[g][l] <= zero_reg[g-1][l];
                    if (!y_reg[g-1][l][CW-1]) begin
                        x_reg[g][l] <= x_reg[g-1][l] + (y_reg[g-1][l] >>> (g - 1));
                        y_reg[g][l] <= y_reg[g-1][l] - (x_reg[g-1][l] >>> (g - 1));
                        z_reg[g][l] <= z_reg[g-1][l] + ATAN;
                    end else begin
                        x_reg[g][l] <= x_reg[g-1][l] - (y_reg[g-1][l] >>> (g - 1));
                        y_reg[g][l] <= y_reg[g-1][l] + (x_reg[g-1][l] >>> (g - 1));
                        z_reg[g][l] <= z_reg[g-1][l] - ATAN;
                    end
                end
            end
        end
    end

    assign out_valid   = vld_reg[N-1];
    assign out_zero    = zero_reg[N-1];
    assign out_clamped = clamp_reg[N-1];
    for (genvar l = 0; l < L; l++) begin : g_out
        assign out_z[l] = z_reg[N-1][l];
    end

endmodule

FILE: rtl/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the result channel of the angle converter.
// ----------------------------------------------------------------------------
module qte_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [qte_pkg::ROLL_W-1:0]   m_roll,
    input logic signed [qte_pkg::PITCH_W-1:0]  m_pitch,
    input logic signed [qte_pkg::YAW_W-1:0]    m_yaw,
    input logic                                m_pitch_clamped
);

    // No result transaction is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_roll) && $stable(m_pitch)
            && $stable(m_yaw) && $stable(m_pitch_clamped))
        else $error("stalled result changed");

    // Roll and yaw stay within plus or minus pi.
    a_roll_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_roll <= 16'sd25736 && m_roll >= -16'sd25736
            && m_yaw <= 16'sd25736 && m_yaw >= -16'sd25736)
        else $error("roll or yaw out of range");

    // Pitch stays within plus or minus half pi.
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pitch <= 15'sd12868 && m_pitch >= -15'sd12868)
        else $error("pitch out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (.*);
